// File: src/shc_pkg.sv
`default_nettype none

package shc_pkg;

  localparam int ALPHABET_DEF     = 256;
  localparam int COUNT_BITS_DEF   = 32;
  localparam int MAX_CODE_LEN_DEF = 48;

  localparam int REQ_W  = 2;
  localparam int SYM_W  = 8;
  localparam int LOAD_W = 32;
  localparam int KIND_W = 2;
  localparam int CODE_W = 48;
  localparam int OLEN_W = 6;
  localparam int LEN_W  = 8;
  localparam int NODE_W = 9;

  typedef enum logic [REQ_W-1:0] {
    REQ_COUNT  = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_DECODE = 2'd2,
    REQ_LOAD   = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CODE   = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN,
    B_FETCH,
    B_FCAP,
    B_PICK,
    B_CREATE,
    B_CA_INIT,
    B_CA_RD,
    B_CA_WL,
    B_CA_WR,
    B_DONE
  } bstate_t;

  typedef struct packed {
    logic              done;
    logic              empty;
    logic              single;
    logic [NODE_W-1:0] root;
  } shc_bstat_t;

endpackage

`default_nettype wire

// File: src/shc_build.sv
`default_nettype none

module shc_build #(
  parameter int ALPHABET   = shc_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = shc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  input  wire logic [ALPHABET-1:0]                        leaf_vld,
  input  wire logic [COUNT_BITS+$clog2(ALPHABET)+2*shc_pkg::NODE_W-1:0] nd_rdata,
  input  wire logic [shc_pkg::CODE_W+shc_pkg::LEN_W-1:0]  cd_rdata,
  output logic      [shc_pkg::NODE_W-1:0]                 nd_raddr,
  output logic                                            nd_we,
  output logic      [shc_pkg::NODE_W-1:0]                 nd_waddr,
  output logic [COUNT_BITS+$clog2(ALPHABET)+2*shc_pkg::NODE_W-1:0] nd_wdata,
  output logic      [shc_pkg::NODE_W-1:0]                 cd_raddr,
  output logic                                            cd_we,
  output logic      [shc_pkg::NODE_W-1:0]                 cd_waddr,
  output logic      [shc_pkg::CODE_W+shc_pkg::LEN_W-1:0]  cd_wdata,
  output shc_pkg::shc_bstat_t                             stat
);
  import shc_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET);
  localparam int WGT_W = COUNT_BITS + IDX_W;
  localparam int ND_W  = WGT_W + 2 * NODE_W;
  localparam int CD_W  = CODE_W + LEN_W;
  localparam int CNT_W = IDX_W + 1;

  bstate_t bst_r, bst_nxt;

  logic [CNT_W-1:0]  scan_addr_r;
  logic              scan_pend_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic              first_r;
  logic [WGT_W-1:0]  prev_w_r;
  logic [IDX_W-1:0]  prev_idx_r;
  logic              best_vld_r;
  logic [WGT_W-1:0]  best_w_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [CNT_W-1:0]  leaf_tot_r;
  logic [NODE_W-1:0] next_int_r;
  logic [NODE_W-1:0] iq_head_r;
  logic [WGT_W-1:0]  iq_w_r;
  logic [WGT_W-1:0]  a_w_r;
  logic [NODE_W-1:0] a_idx_r;
  logic [WGT_W-1:0]  b_w_r;
  logic [NODE_W-1:0] b_idx_r;
  logic              b_leaf_r;
  logic              second_r;
  logic [NODE_W-1:0] n_r;
  logic [NODE_W-1:0] rch_r;
  logic [CODE_W-1:0] pcode_r;
  logic [LEN_W-1:0]  plen_r;
  logic [NODE_W-1:0] root_r;
  logic              empty_r;
  logic              single_r;

  logic [WGT_W-1:0]  rd_w;
  logic [NODE_W-1:0] rd_left;
  logic [NODE_W-1:0] rd_right;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [WGT_W-1:0]  s_w;
  logic              s_after;
  logic              s_take;
  logic              scan_end;
  logic              iq_ok;
  logic              take_leaf;
  logic [WGT_W-1:0]  ch_w;
  logic [NODE_W-1:0] ch_idx;
  logic              last_merge;

  assign rd_w     = nd_rdata[ND_W-1 -: WGT_W];
  assign rd_left  = nd_rdata[2*NODE_W-1 -: NODE_W];
  assign rd_right = nd_rdata[NODE_W-1:0];
  assign rd_code  = cd_rdata[CD_W-1 -: CODE_W];
  assign rd_len   = cd_rdata[LEN_W-1:0];

  always_comb begin
    s_w      = leaf_vld[scan_idx_r] ? rd_w : '0;
    s_after  = first_r || (s_w > prev_w_r) ||
               ((s_w == prev_w_r) && (scan_idx_r > prev_idx_r));
    s_take   = scan_pend_r && (s_w != '0) && s_after &&
               (!best_vld_r || (s_w < best_w_r));
    scan_end = (scan_addr_r == CNT_W'(ALPHABET)) && !scan_pend_r;
    iq_ok     = iq_head_r != next_int_r;
    take_leaf = best_vld_r && (!iq_ok || (best_w_r <= iq_w_r));
    ch_w      = take_leaf ? best_w_r : iq_w_r;
    ch_idx    = take_leaf ? NODE_W'(best_idx_r) : iq_head_r;
    last_merge = ((NODE_W+1)'(next_int_r) + (NODE_W+1)'(2)) ==
                 ((NODE_W+1)'(ALPHABET) + (NODE_W+1)'(leaf_tot_r));
  end

  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_IDLE: begin
        if (start) begin
          bst_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_end) begin
          if (first_r && (leaf_tot_r < CNT_W'(2))) begin
            bst_nxt = B_DONE;
          end else begin
            bst_nxt = B_FETCH;
          end
        end
      end
      B_FETCH: bst_nxt = B_FCAP;
      B_FCAP:  bst_nxt = B_PICK;
      B_PICK: begin
        if (second_r) begin
          bst_nxt = B_CREATE;
        end else if (take_leaf) begin
          bst_nxt = B_SCAN;
        end else begin
          bst_nxt = B_FETCH;
        end
      end
      B_CREATE: begin
        if (last_merge) begin
          bst_nxt = B_CA_INIT;
        end else if (b_leaf_r) begin
          bst_nxt = B_SCAN;
        end else begin
          bst_nxt = B_FETCH;
        end
      end
      B_CA_INIT: bst_nxt = B_CA_RD;
      B_CA_RD:   bst_nxt = B_CA_WL;
      B_CA_WL:   bst_nxt = B_CA_WR;
      B_CA_WR: begin
        if (n_r == NODE_W'(ALPHABET)) begin
          bst_nxt = B_DONE;
        end else begin
          bst_nxt = B_CA_RD;
        end
      end
      B_DONE:  bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    nd_raddr = NODE_W'(scan_addr_r);
    cd_raddr = n_r;
    nd_we    = 1'b0;
    nd_waddr = next_int_r;
    nd_wdata = {WGT_W'(a_w_r + b_w_r), a_idx_r, b_idx_r};
    cd_we    = 1'b0;
    cd_waddr = root_r;
    cd_wdata = '0;
    unique case (bst_r)
      B_FETCH:   nd_raddr = iq_head_r;
      B_CA_RD:   nd_raddr = n_r;
      B_CREATE:  nd_we = 1'b1;
      B_CA_INIT: cd_we = 1'b1;
      B_CA_WL: begin
        cd_we    = 1'b1;
        cd_waddr = rd_left;
        cd_wdata = {rd_code[CODE_W-2:0], 1'b0, LEN_W'(rd_len + LEN_W'(1))};
      end
      B_CA_WR: begin
        cd_we    = 1'b1;
        cd_waddr = rch_r;
        cd_wdata = {pcode_r[CODE_W-2:0], 1'b1, LEN_W'(plen_r + LEN_W'(1))};
      end
      default: ;
    endcase
    stat.done   = bst_r == B_DONE;
    stat.empty  = empty_r;
    stat.single = single_r;
    stat.root   = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      scan_pend_r <= 1'b0;
      best_vld_r  <= 1'b0;
      second_r    <= 1'b0;
      empty_r     <= 1'b0;
      single_r    <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      scan_pend_r <= (bst_r == B_SCAN) && (scan_addr_r != CNT_W'(ALPHABET));
      if (start && (bst_r == B_IDLE)) begin
        second_r <= 1'b0;
        empty_r  <= 1'b0;
        single_r <= 1'b0;
      end
      if ((bst_nxt == B_SCAN) && (bst_r != B_SCAN)) begin
        best_vld_r <= 1'b0;
      end else if (s_take) begin
        best_vld_r <= 1'b1;
      end
      if ((bst_r == B_SCAN) && scan_end && first_r) begin
        empty_r  <= leaf_tot_r == '0;
        single_r <= leaf_tot_r == CNT_W'(1);
      end
      if (bst_r == B_PICK) begin
        second_r <= !second_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((bst_nxt == B_SCAN) && (bst_r != B_SCAN)) begin
      scan_addr_r <= '0;
    end else if ((bst_r == B_SCAN) && (scan_addr_r != CNT_W'(ALPHABET))) begin
      scan_addr_r <= scan_addr_r + CNT_W'(1);
    end
    scan_idx_r <= scan_addr_r[IDX_W-1:0];
    if (s_take) begin
      best_w_r   <= s_w;
      best_idx_r <= scan_idx_r;
    end
    if (start && (bst_r == B_IDLE)) begin
      first_r    <= 1'b1;
      leaf_tot_r <= '0;
      next_int_r <= NODE_W'(ALPHABET);
      iq_head_r  <= NODE_W'(ALPHABET);
      root_r     <= '0;
    end
    if ((bst_r == B_SCAN) && first_r && scan_pend_r && (s_w != '0)) begin
      leaf_tot_r <= leaf_tot_r + CNT_W'(1);
    end
    if ((bst_r == B_SCAN) && scan_end) begin
      first_r <= 1'b0;
      if (first_r) begin
        root_r <= NODE_W'(best_idx_r);
      end
    end
    if (bst_r == B_FCAP) begin
      iq_w_r <= rd_w;
    end
    if (bst_r == B_PICK) begin
      if (second_r) begin
        b_w_r    <= ch_w;
        b_idx_r  <= ch_idx;
        b_leaf_r <= take_leaf;
      end else begin
        a_w_r   <= ch_w;
        a_idx_r <= ch_idx;
      end
      if (take_leaf) begin
        prev_w_r   <= best_w_r;
        prev_idx_r <= best_idx_r;
      end else begin
        iq_head_r <= iq_head_r + NODE_W'(1);
      end
    end
    if (bst_r == B_CREATE) begin
      root_r     <= next_int_r;
      next_int_r <= next_int_r + NODE_W'(1);
    end
    if (bst_r == B_CA_INIT) begin
      n_r <= root_r;
    end
    if (bst_r == B_CA_WL) begin
      rch_r   <= rd_right;
      pcode_r <= rd_code;
      plen_r  <= rd_len;
    end
    if (bst_r == B_CA_WR) begin
      n_r <= n_r - NODE_W'(1);
    end
  end

  a_pick_has_node: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == B_PICK) |-> (best_vld_r || (iq_head_r != next_int_r)))
    else $error("merge step found no node to take");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (bst_r == B_DONE) |=> (bst_r == B_IDLE))
    else $error("build done not followed by idle");

  a_single_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(single_r && empty_r))
    else $error("tree flagged both empty and single");

endmodule

`default_nettype wire

// File: src/static_huffman_codec.sv
`default_nettype none

// Count, load, encode and decode words read the node and code memories when accepted; in the
// execute state count and load then update the node memory and encode and decode register
// any result. The first encode or decode word after any count or load rebuilds the tree while
// input is held off; the rebuild finds each next-lightest leaf by a scan of the symbol table
// through the single node memory read port. Frequency counts reset through per-symbol valid
// bits, so no clearing pass follows reset.
module static_huffman_codec #(
  parameter int ALPHABET     = shc_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS   = shc_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_LEN = shc_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [shc_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [shc_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic                          in_code_bit,
  input  wire logic [shc_pkg::LOAD_W-1:0]    in_load_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [shc_pkg::KIND_W-1:0]    out_result_kind,
  output logic      [shc_pkg::CODE_W-1:0]    out_code_word,
  output logic      [shc_pkg::OLEN_W-1:0]    out_code_length,
  output logic      [shc_pkg::SYM_W-1:0]     out_decoded_symbol
);
  import shc_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET);
  localparam int WGT_W = COUNT_BITS + IDX_W;
  localparam int ND_W  = WGT_W + 2 * NODE_W;
  localparam int CD_W  = CODE_W + LEN_W;
  localparam int NODES = 2 * ALPHABET - 1;
  localparam logic [63:0] CMAX64 = (64'(1) << COUNT_BITS) - 64'(1);
  localparam logic [WGT_W-1:0] CMAX = WGT_W'(CMAX64);

  state_t state_r, state_nxt;

  logic [ALPHABET-1:0] leaf_vld_r;
  req_t                req_r;
  logic [SYM_W-1:0]    sym_r;
  logic                bit_r;
  logic [LOAD_W-1:0]   load_r;
  logic                tree_valid_r;
  logic [NODE_W-1:0]   walk_r, walk_nxt;
  logic                out_valid_r;
  kind_t               kind_r;
  logic [CODE_W-1:0]   word_r;
  logic [OLEN_W-1:0]   len_r;
  logic [SYM_W-1:0]    dsym_r;

  logic [ND_W-1:0] node_mem [NODES];
  logic [CD_W-1:0] code_mem [NODES];
  logic [ND_W-1:0] nd_rdata;
  logic [CD_W-1:0] cd_rdata;

  logic              nd_we;
  logic [NODE_W-1:0] nd_waddr, nd_raddr, cd_raddr;
  logic [ND_W-1:0]   nd_wdata;

  logic              b_nd_we, b_cd_we;
  logic [NODE_W-1:0] b_nd_raddr, b_nd_waddr, b_cd_raddr, b_cd_waddr;
  logic [ND_W-1:0]   b_nd_wdata;
  logic [CD_W-1:0]   b_cd_wdata;
  shc_bstat_t        bstat;

  logic              accept;
  req_t              in_req;
  logic              need_build;
  logic [SYM_W-1:0]  rd_sym;
  logic              rd_dec;
  logic              sym_ok;
  logic [WGT_W-1:0]  cur_cnt;
  logic [63:0]       load_sat;
  logic              ex_we;
  logic [WGT_W-1:0]  ex_cnt;
  logic [NODE_W-1:0] dec_nxt;
  logic [LEN_W-1:0]  rd_len;
  logic              res_v;
  kind_t             res_kind;
  logic [CODE_W-1:0] res_word;
  logic [OLEN_W-1:0] res_len;
  logic [SYM_W-1:0]  res_sym;

  assign in_req     = req_t'(in_req_type);
  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept     = in_valid && in_ready;
  assign need_build = accept && !tree_valid_r &&
                      ((in_req == REQ_ENCODE) || (in_req == REQ_DECODE));

  shc_build #(
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_build (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (need_build),
    .leaf_vld (leaf_vld_r),
    .nd_rdata (nd_rdata),
    .cd_rdata (cd_rdata),
    .nd_raddr (b_nd_raddr),
    .nd_we    (b_nd_we),
    .nd_waddr (b_nd_waddr),
    .nd_wdata (b_nd_wdata),
    .cd_raddr (b_cd_raddr),
    .cd_we    (b_cd_we),
    .cd_waddr (b_cd_waddr),
    .cd_wdata (b_cd_wdata),
    .stat     (bstat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = need_build ? ST_BUILD : ST_EXEC;
        end
      end
      ST_BUILD: begin
        if (bstat.done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_sym   = (state_r == ST_IDLE) ? in_symbol : sym_r;
    rd_dec   = (state_r == ST_IDLE) ? (in_req == REQ_DECODE) : (req_r == REQ_DECODE);
    nd_raddr = rd_dec ? walk_r : NODE_W'(rd_sym);
    cd_raddr = NODE_W'(rd_sym);
    if (state_r == ST_BUILD) begin
      nd_raddr = b_nd_raddr;
      cd_raddr = b_cd_raddr;
    end
  end

  always_comb begin
    sym_ok   = 32'(sym_r) < ALPHABET;
    cur_cnt  = leaf_vld_r[sym_r[IDX_W-1:0]] ? nd_rdata[ND_W-1 -: WGT_W] : '0;
    load_sat = (64'(load_r) > CMAX64) ? CMAX64 : 64'(load_r);
    ex_we    = (state_r == ST_EXEC) && sym_ok &&
               ((req_r == REQ_COUNT) || (req_r == REQ_LOAD));
    if (req_r == REQ_LOAD) begin
      ex_cnt = WGT_W'(load_sat);
    end else if (cur_cnt == CMAX) begin
      ex_cnt = cur_cnt;
    end else begin
      ex_cnt = cur_cnt + WGT_W'(1);
    end
    nd_we    = ex_we || b_nd_we;
    nd_waddr = ex_we ? NODE_W'(sym_r) : b_nd_waddr;
    nd_wdata = ex_we ? {ex_cnt, {(2*NODE_W){1'b0}}} : b_nd_wdata;
  end

  always_comb begin
    res_v    = 1'b0;
    res_kind = KIND_ERROR;
    res_word = '0;
    res_len  = '0;
    res_sym  = '0;
    walk_nxt = walk_r;
    rd_len   = cd_rdata[LEN_W-1:0];
    dec_nxt  = bit_r ? nd_rdata[NODE_W-1:0] : nd_rdata[2*NODE_W-1 -: NODE_W];
    if (bstat.done) begin
      walk_nxt = bstat.root;
    end
    if (state_r == ST_EXEC) begin
      unique case (req_r)
        REQ_ENCODE: begin
          res_v = 1'b1;
          if (!bstat.empty && sym_ok && (cur_cnt != '0)) begin
            if (bstat.single) begin
              res_kind = KIND_CODE;
              res_len  = OLEN_W'(1);
            end else if (32'(rd_len) <= MAX_CODE_LEN) begin
              res_kind = KIND_CODE;
              res_word = cd_rdata[CD_W-1 -: CODE_W];
              res_len  = OLEN_W'(rd_len);
            end
          end
        end
        REQ_DECODE: begin
          if (bstat.empty) begin
            res_v = 1'b1;
          end else if (bstat.single) begin
            res_v    = 1'b1;
            res_kind = KIND_SYMBOL;
            res_sym  = SYM_W'(bstat.root);
          end else if (32'(dec_nxt) < ALPHABET) begin
            res_v    = 1'b1;
            res_kind = KIND_SYMBOL;
            res_sym  = SYM_W'(dec_nxt);
            walk_nxt = bstat.root;
          end else begin
            walk_nxt = dec_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (nd_we) begin
      node_mem[nd_waddr] <= nd_wdata;
    end
    nd_rdata <= node_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_cd_we) begin
      code_mem[b_cd_waddr] <= b_cd_wdata;
    end
    cd_rdata <= code_mem[cd_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      leaf_vld_r   <= '0;
      tree_valid_r <= 1'b0;
      walk_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
      if (ex_we) begin
        leaf_vld_r[sym_r[IDX_W-1:0]] <= 1'b1;
        tree_valid_r <= 1'b0;
      end else if (bstat.done) begin
        tree_valid_r <= 1'b1;
      end
      if (res_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req;
      sym_r  <= in_symbol;
      bit_r  <= in_code_bit;
      load_r <= in_load_count;
    end
    if (res_v) begin
      kind_r <= res_kind;
      word_r <= res_word;
      len_r  <= res_len;
      dsym_r <= res_sym;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_code_word      = word_r;
  assign out_code_length    = len_r;
  assign out_decoded_symbol = dsym_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("accepted word did not start execution");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !out_valid_r)
    else $error("result slot occupied while executing");

  a_build_sets_tree: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.done |=> tree_valid_r)
    else $error("tree not marked valid after rebuild");

  a_build_writes_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    (b_nd_we || b_cd_we) |-> (state_r == ST_BUILD))
    else $error("rebuild wrote memory outside of a rebuild");

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shc_pkg::*;

  localparam int NSYM = 256;
  localparam int NNODE = 2 * NSYM - 1;
  localparam int MAXLEN = 48;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    kind_t       kind;
    logic [47:0] word;
    logic [5:0]  len;
    logic [7:0]  sym;
  } huff_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [SYM_W-1:0] in_symbol = '0;
  logic in_code_bit = 0;
  logic [LOAD_W-1:0] in_load_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [KIND_W-1:0] out_result_kind;
  logic [CODE_W-1:0] out_code_word;
  logic [OLEN_W-1:0] out_code_length;
  logic [SYM_W-1:0] out_decoded_symbol;

  static_huffman_codec dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_symbol(in_symbol), .in_code_bit(in_code_bit), .in_load_count(in_load_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_code_word(out_code_word), .out_code_length(out_code_length),
    .out_decoded_symbol(out_decoded_symbol)
  );

  huff_result_t pending_q[$];
  int errors = 0;
  bit quiet = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int words_sent = 0;

  logic [31:0] freq[NSYM];
  bit tree_ok;
  int leaves, root, walk, lst_head, lst_len;
  longint unsigned wt[NNODE];
  int lch[NNODE], rch[NNODE], nxt[NNODE];
  longint unsigned code_of[NSYM], tcode[NNODE];
  int len_of[NSYM], tlen[NNODE];

  always #4 clk = ~clk;

  function automatic void insert_node(int n);
    int cur, prev, k;
    bit has_prev;
    cur = lst_head;
    prev = 0;
    has_prev = 0;
    for (k = 0; k < lst_len; k++) begin
      if (wt[n] < wt[cur]) break;
      prev = cur;
      has_prev = 1;
      cur = nxt[cur];
    end
    nxt[n] = cur;
    if (has_prev) nxt[prev] = n;
    else lst_head = n;
    lst_len++;
  endfunction

  function automatic void rebuild_tree();
    int s, n, a, b, m;
    lst_head = 0;
    lst_len = 0;
    m = NSYM;
    for (s = 0; s < NSYM; s++) begin
      if (freq[s] != 0) begin
        wt[s] = 64'(freq[s]);
        insert_node(s);
      end
    end
    leaves = lst_len;
    tree_ok = 1;
    if (lst_len == 0) begin
      root = 0;
      walk = 0;
      return;
    end
    while (lst_len > 1) begin
      a = lst_head;
      b = nxt[a];
      wt[m] = wt[a] + wt[b];
      lch[m] = a;
      rch[m] = b;
      lst_head = nxt[b];
      lst_len -= 2;
      insert_node(m);
      m++;
    end
    root = lst_head;
    walk = lst_head;
    if (leaves == 1) begin
      code_of[root] = 0;
      len_of[root] = 1;
      return;
    end
    tcode[root] = 0;
    tlen[root] = 0;
    for (n = m - 1; n >= NSYM; n--) begin
      tcode[lch[n]] = tcode[n] << 1;
      tcode[rch[n]] = (tcode[n] << 1) | 1;
      tlen[lch[n]] = tlen[n] + 1;
      tlen[rch[n]] = tlen[n] + 1;
    end
    for (s = 0; s < NSYM; s++) begin
      if (freq[s] != 0) begin
        code_of[s] = tcode[s];
        len_of[s] = tlen[s];
      end
    end
  endfunction

  function automatic void predict_word(req_t req, int sym, bit cbit, logic [31:0] load);
    huff_result_t r;
    int pos, step;
    r.kind = KIND_ERROR;
    r.word = '0;
    r.len = '0;
    r.sym = '0;
    if (req == REQ_COUNT || req == REQ_LOAD) begin
      if (req == REQ_COUNT) begin
        if (freq[sym] != 32'hFFFF_FFFF) freq[sym]++;
      end else begin
        freq[sym] = load;
      end
      tree_ok = 0;
      return;
    end
    if (!tree_ok) rebuild_tree();
    if (leaves == 0) begin
      pending_q.push_back(r);
      return;
    end
    if (req == REQ_ENCODE) begin
      if (freq[sym] != 0 && len_of[sym] <= MAXLEN) begin
        r.kind = KIND_CODE;
        r.word = code_of[sym][47:0];
        r.len = 6'(len_of[sym]);
      end
      pending_q.push_back(r);
      return;
    end
    r.kind = KIND_SYMBOL;
    if (leaves == 1) begin
      r.sym = 8'(root);
      pending_q.push_back(r);
      return;
    end
    pos = walk;
    if (pos < NSYM || pos >= NNODE) pos = root;
    step = cbit ? rch[pos] : lch[pos];
    if (step < NSYM) begin
      walk = root;
      r.sym = 8'(step);
      pending_q.push_back(r);
    end else begin
      walk = step;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    huff_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", out_result_kind, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_result_kind != e.kind) report_mismatch("kind", out_result_kind, e.kind);
        if (out_code_word != e.word) report_mismatch("code", out_code_word, e.word);
        if (out_code_length != e.len) report_mismatch("length", out_code_length, e.len);
        if (out_decoded_symbol != e.sym)
          report_mismatch("symbol", out_decoded_symbol, e.sym);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(req_t req, int sym, bit cbit = 0, logic [31:0] load = 0);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_symbol <= 8'(sym);
    in_code_bit <= cbit;
    in_load_count <= load;
    do @(posedge clk); while (!in_ready);
    predict_word(req, sym, cbit, load);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic clear_table();
    int s;
    for (s = 0; s < NSYM; s++)
      if (freq[s] != 0) send_word(REQ_LOAD, s, $urandom_range(0, 1), 0);
  endtask

  task automatic test_empty_table();
    send_word(REQ_ENCODE, 0);
    send_word(REQ_DECODE, 255, 1);
    send_word(REQ_DECODE, 7, 0);
  endtask

  task automatic test_single_symbol();
    send_word(REQ_COUNT, 255);
    send_word(REQ_ENCODE, 255);
    send_word(REQ_ENCODE, 0);
    send_word(REQ_DECODE, 0, 0);
    send_word(REQ_DECODE, 0, 1);
    send_word(REQ_LOAD, 255, 0, 32'hFFFF_FFFF);
    send_word(REQ_COUNT, 255);
    send_word(REQ_ENCODE, 255);
  endtask

  task automatic test_small_tree();
    send_word(REQ_LOAD, 0, 0, 5);
    send_word(REQ_LOAD, 1, 0, 5);
    send_word(REQ_LOAD, 128, 1, 10);
    send_word(REQ_COUNT, 3);
    send_word(REQ_ENCODE, 0);
    send_word(REQ_ENCODE, 128);
    send_word(REQ_ENCODE, 3);
    send_word(REQ_ENCODE, 2);
    send_word(REQ_DECODE, 0, 1);
    send_word(REQ_DECODE, 0, 0);
    send_word(REQ_DECODE, 0, 0);
    send_word(REQ_DECODE, 0, 0);
    send_word(REQ_DECODE, 0, 1);
    drain();
    clear_table();
  endtask

  task automatic test_deep_tree();
    longint unsigned a, b, c;
    int s;
    a = 1;
    b = 1;
    for (s = 0; s < 48; s++) begin
      send_word(REQ_LOAD, s, 0, a > 32'hFFFF_FFFF ? 32'hFFFF_FFFF : a[31:0]);
      c = a + b;
      a = b;
      b = c;
    end
    for (s = 0; s < 48; s++) send_word(REQ_ENCODE, s);
    for (s = 0; s < 60; s++) send_word(REQ_DECODE, 0, s < 50);
    drain();
    clear_table();
  endtask

  task automatic test_full_alphabet();
    int s;
    for (s = 0; s < NSYM; s++) send_word(REQ_LOAD, s, 0, $urandom_range(0, 3) == 0 ? $urandom : s + 1);
    for (s = 0; s < 40; s++) send_word(REQ_ENCODE, $urandom_range(0, 255));
    for (s = 0; s < 40; s++) send_word(REQ_DECODE, $urandom, $urandom_range(0, 1));
    drain();
    clear_table();
  endtask

  task automatic test_random_streams(int target);
    int syms[$];
    int n, k, ops;
    logic [31:0] v;
    while (words_sent < target) begin
      if (words_sent > target - 150) quiet = 1;
      syms.delete();
      n = $urandom_range(1, 16);
      for (k = 0; k < n; k++) begin
        syms.push_back($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: v = $urandom_range(1, 4);
          1: v = $urandom;
          2: v = 32'hFFFF_FFFF - $urandom_range(0, 2);
          default: v = $urandom_range(0, 1000);
        endcase
        if ($urandom_range(0, 4) == 0) send_word(REQ_COUNT, syms[k], $urandom_range(0, 1), $urandom);
        else send_word(REQ_LOAD, syms[k], $urandom_range(0, 1), v);
      end
      ops = $urandom_range(20, 60);
      for (k = 0; k < ops; k++) begin
        case ($urandom_range(0, 19))
          0: send_word(REQ_COUNT, syms[$urandom_range(0, n - 1)], $urandom_range(0, 1), $urandom);
          1: send_word(REQ_LOAD, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 3));
          2, 3: send_word(REQ_ENCODE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom);
          4, 5, 6, 7, 8, 9:
            send_word(REQ_ENCODE, syms[$urandom_range(0, n - 1)], $urandom_range(0, 1), $urandom);
          default: send_word(REQ_DECODE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom);
        endcase
      end
      if ($urandom_range(0, 3) == 0) drain();
      if ($urandom_range(0, 1) == 0) clear_table();
    end
  endtask

  initial begin
    int s;
    for (s = 0; s < NSYM; s++) freq[s] = 0;
    tree_ok = 0;
    leaves = 0;
    root = 0;
    walk = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_empty_table();
    test_single_symbol();
    drain();
    clear_table();
    test_small_tree();
    test_deep_tree();
    test_full_alphabet();
    test_random_streams(1600);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
